// ----- design/dns_pkg.sv -----
// ----------------------------------------------------------------------------
// dns_pkg
// Shared codes, state type and controller/datapath command and status
// bundles for the directional nearest selector.
// ----------------------------------------------------------------------------
package dns_pkg;

    localparam int ID_BITS  = 16;
    localparam int DIM_BITS = 15;

    // request modes
    localparam logic [1:0] MODE_CLEAR  = 2'd0;
    localparam logic [1:0] MODE_APPEND = 2'd1;
    localparam logic [1:0] MODE_QUERY  = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FOUND     = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_DROPPED   = 2'd3;

    // query directions
    localparam logic [1:0] DIR_LEFT  = 2'd0;
    localparam logic [1:0] DIR_RIGHT = 2'd1;
    localparam logic [1:0] DIR_UP    = 2'd2;
    localparam logic [1:0] DIR_DOWN  = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_SEARCH,
        S_SEARCH_DRAIN,
        S_SCAN,
        S_SCAN_DRAIN,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic accept;      // latch the incoming request
        logic exec;        // clear / append, arm the origin search
        logic rd;          // read the entry at the scan index, advance it
        logic scan_start;  // rewind the index, arm the cone scan
        logic finish;      // load the result register
    } t_dp_cmd;

    typedef struct packed {
        logic is_query;
        logic vid_zero;
        logic have_org;
        logic idx_done;
        logic pipe_busy;
        logic out_free;
    } t_dp_sts;

endpackage

// ----- design/dns_req_if.sv -----
// ----------------------------------------------------------------------------
// dns_req_if
// Request channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
interface dns_req_if #(
    parameter int COORD_BITS = 16
);
    logic                         valid;
    logic                         ready;
    logic [1:0]                   mode;
    logic [dns_pkg::ID_BITS-1:0]  view_id;
    logic signed [COORD_BITS-1:0] box_x;
    logic signed [COORD_BITS-1:0] box_y;
    logic [dns_pkg::DIM_BITS-1:0] box_width;
    logic [dns_pkg::DIM_BITS-1:0] box_height;
    logic [1:0]                   direction;

    modport source (
        output valid, mode, view_id, box_x, box_y, box_width, box_height, direction,
        input  ready
    );
    modport sink (
        input  valid, mode, view_id, box_x, box_y, box_width, box_height, direction,
        output ready
    );
endinterface

// ----- design/dns_rsp_if.sv -----
// ----------------------------------------------------------------------------
// dns_rsp_if
// Result channel: valid/ready handshake with status and chosen identifier.
// ----------------------------------------------------------------------------
interface dns_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [dns_pkg::ID_BITS-1:0] chosen_id;

    modport source (
        output valid, status, chosen_id,
        input  ready
    );
    modport sink (
        input  valid, status, chosen_id,
        output ready
    );
endinterface

// ----- design/dns_ram.sv -----
// ----------------------------------------------------------------------------
// dns_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module dns_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                         i_clk,
    input  logic                                         i_wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]                             i_wr_data,
    input  logic                                         i_rd_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]                             o_rd_data
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

// ----- design/dns_ctrl.sv -----
// ----------------------------------------------------------------------------
// dns_ctrl
// Sequencer: takes one request, steps the datapath through the origin search
// and cone scan of a query, then hands the result to the output register.
// ----------------------------------------------------------------------------
module dns_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    output logic             o_req_ready,
    input  dns_pkg::t_dp_sts i_sts,
    output dns_pkg::t_dp_cmd o_cmd
);
    dns_pkg::t_state r_state;
    dns_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dns_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dns_pkg::S_IDLE: begin
                if (i_req_valid) n_state = dns_pkg::S_EXEC;
            end
            dns_pkg::S_EXEC: begin
                n_state = i_sts.is_query ? dns_pkg::S_SEARCH : dns_pkg::S_FINISH;
            end
            dns_pkg::S_SEARCH: begin
                if (i_sts.idx_done) n_state = dns_pkg::S_SEARCH_DRAIN;
            end
            dns_pkg::S_SEARCH_DRAIN: begin
                if (!i_sts.pipe_busy) begin
                    if (i_sts.vid_zero || !i_sts.have_org) begin
                        n_state = dns_pkg::S_FINISH;
                    end else begin
                        n_state = dns_pkg::S_SCAN;
                    end
                end
            end
            dns_pkg::S_SCAN: begin
                if (i_sts.idx_done) n_state = dns_pkg::S_SCAN_DRAIN;
            end
            dns_pkg::S_SCAN_DRAIN: begin
                if (!i_sts.pipe_busy) n_state = dns_pkg::S_FINISH;
            end
            dns_pkg::S_FINISH: begin
                if (i_sts.out_free) n_state = dns_pkg::S_IDLE;
            end
            default: n_state = dns_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_req_ready = 1'b0;
        unique case (r_state)
            dns_pkg::S_IDLE: begin
                o_req_ready  = 1'b1;
                o_cmd.accept = i_req_valid;
            end
            dns_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
            end
            dns_pkg::S_SEARCH, dns_pkg::S_SCAN: begin
                o_cmd.rd = !i_sts.idx_done;
            end
            dns_pkg::S_SEARCH_DRAIN: begin
                // rewind for the scan once the search has drained
                o_cmd.scan_start = !i_sts.pipe_busy;
            end
            dns_pkg::S_SCAN_DRAIN: begin
                o_cmd.rd = 1'b0;
            end
            dns_pkg::S_FINISH: begin
                o_cmd.finish = i_sts.out_free;
            end
            default: begin
                o_cmd = '0;
            end
        endcase
    end
endmodule

// ----- design/dns_datapath.sv -----
// ----------------------------------------------------------------------------
// dns_datapath
// Entry table, origin capture, five-stage cone/distance pipeline, best
// candidate tracking and the result register.
// ----------------------------------------------------------------------------
module dns_datapath #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  dns_pkg::t_dp_cmd                    i_cmd,
    output dns_pkg::t_dp_sts                    o_sts,
    input  logic [1:0]                          i_mode,
    input  logic [dns_pkg::ID_BITS-1:0]         i_view_id,
    input  logic signed [COORD_BITS-1:0]        i_box_x,
    input  logic signed [COORD_BITS-1:0]        i_box_y,
    input  logic [dns_pkg::DIM_BITS-1:0]        i_box_width,
    input  logic [dns_pkg::DIM_BITS-1:0]        i_box_height,
    input  logic [1:0]                          i_direction,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [1:0]                          o_status,
    output logic [dns_pkg::ID_BITS-1:0]         o_chosen_id
);
    localparam int IDB = dns_pkg::ID_BITS;
    localparam int DMB = dns_pkg::DIM_BITS;
    localparam int CW  = ((COORD_BITS > DMB) ? COORD_BITS : DMB) + 2;  // doubled centre
    localparam int DW  = CW + 1;                                       // centre difference
    localparam int MW  = CW;                                           // difference magnitude
    localparam int QW  = 2 * MW;                                       // one square
    localparam int SW  = QW + 1;                                       // sum of squares
    localparam int EW  = IDB + 2 * COORD_BITS + 2 * DMB;
    localparam int AW  = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int IW  = $clog2(MAX_ENTRIES + 1);
    localparam logic [IW-1:0] MAX_CNT = IW'(MAX_ENTRIES);

    // latched request
    logic [1:0]                   r_mode;
    logic [IDB-1:0]               r_vid;
    logic signed [COORD_BITS-1:0] r_x;
    logic signed [COORD_BITS-1:0] r_y;
    logic [DMB-1:0]               r_w;
    logic [DMB-1:0]               r_h;
    logic [1:0]                   r_dir;

    logic [IW-1:0]  r_count;
    logic [IW-1:0]  r_idx;
    logic           r_scan;
    logic           r_dropped;
    logic           r_got_first;
    logic [IDB-1:0] r_first_id;
    logic           r_have_org;
    logic signed [CW-1:0] r_ox;
    logic signed [CW-1:0] r_oy;
    logic           r_have_best;
    logic [SW-1:0]  r_best_sum;
    logic [IDB-1:0] r_best_id;

    // pipeline
    logic r_v0, r_va, r_vb, r_vc, r_vd;
    logic [IDB-1:0]       r_a_id, r_b_id, r_c_id, r_d_id;
    logic signed [CW-1:0] r_a_cx, r_a_cy;
    logic signed [DW-1:0] r_b_dx, r_b_dy;
    logic                 r_b_skip;
    logic [MW-1:0]        r_c_mx, r_c_my;
    logic [QW-1:0]        r_d_sqx, r_d_sqy;

    logic           r_out_valid;
    logic [1:0]     r_out_status;
    logic [IDB-1:0] r_out_id;

    // table
    logic          w_full;
    logic          w_wr_en;
    logic [EW-1:0] w_wr_data;
    logic [EW-1:0] w_q;

    assign w_full    = (r_count >= MAX_CNT);
    assign w_wr_en   = i_cmd.exec && (r_mode == dns_pkg::MODE_APPEND) && !w_full;
    assign w_wr_data = {r_vid, r_x, r_y, r_w, r_h};

    dns_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_ENTRIES)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_count[AW-1:0]),
        .i_wr_data (w_wr_data),
        .i_rd_en   (i_cmd.rd),
        .i_rd_addr (r_idx[AW-1:0]),
        .o_rd_data (w_q)
    );

    // stage A inputs: unpack and form doubled centres
    logic [IDB-1:0]               w_q_id;
    logic signed [COORD_BITS-1:0] w_q_x;
    logic signed [COORD_BITS-1:0] w_q_y;
    logic [DMB-1:0]               w_q_w;
    logic [DMB-1:0]               w_q_h;
    logic signed [CW-1:0]         w_cx;
    logic signed [CW-1:0]         w_cy;

    assign w_q_id = w_q[EW-1 -: IDB];
    assign w_q_x  = w_q[2*COORD_BITS+2*DMB-1 -: COORD_BITS];
    assign w_q_y  = w_q[COORD_BITS+2*DMB-1 -: COORD_BITS];
    assign w_q_w  = w_q[2*DMB-1 -: DMB];
    assign w_q_h  = w_q[DMB-1:0];
    assign w_cx   = (CW'(w_q_x) <<< 1) + CW'(w_q_w);
    assign w_cy   = (CW'(w_q_y) <<< 1) + CW'(w_q_h);

    // stage C: magnitudes and cone test
    logic          w_dx_neg, w_dy_neg, w_dx_pos, w_dy_pos;
    logic [DW-1:0] w_dx_abs, w_dy_abs;
    logic [MW-1:0] w_mx, w_my;
    logic          w_cone;

    assign w_dx_neg = r_b_dx[DW-1];
    assign w_dy_neg = r_b_dy[DW-1];
    assign w_dx_pos = !w_dx_neg && (r_b_dx != '0);
    assign w_dy_pos = !w_dy_neg && (r_b_dy != '0);
    assign w_dx_abs = w_dx_neg ? DW'(-r_b_dx) : DW'(r_b_dx);
    assign w_dy_abs = w_dy_neg ? DW'(-r_b_dy) : DW'(r_b_dy);
    assign w_mx     = w_dx_abs[MW-1:0];
    assign w_my     = w_dy_abs[MW-1:0];

    always_comb begin
        unique case (r_dir)
            dns_pkg::DIR_LEFT:  w_cone = w_dx_neg && (w_my <= w_mx);
            dns_pkg::DIR_RIGHT: w_cone = w_dx_pos && (w_my <= w_mx);
            dns_pkg::DIR_UP:    w_cone = w_dy_neg && (w_mx <= w_my);
            dns_pkg::DIR_DOWN:  w_cone = w_dy_pos && (w_mx <= w_my);
            default:            w_cone = 1'b0;
        endcase
    end

    // stage E: sum and compare
    logic [SW-1:0] w_sum;
    logic          w_better;

    assign w_sum    = SW'(r_d_sqx) + SW'(r_d_sqy);
    assign w_better = !r_have_best || (w_sum < r_best_sum);

    // result selection
    logic [1:0]     n_out_status;
    logic [IDB-1:0] n_out_id;
    logic           w_found;
    logic [IDB-1:0] w_found_id;

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_idx       <= '0;
            r_scan      <= 1'b0;
            r_dropped   <= 1'b0;
            r_got_first <= 1'b0;
            r_have_org  <= 1'b0;
            r_have_best <= 1'b0;
            r_v0        <= 1'b0;
            r_va        <= 1'b0;
            r_vb        <= 1'b0;
            r_vc        <= 1'b0;
            r_vd        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.exec) begin
                r_idx       <= '0;
                r_scan      <= 1'b0;
                r_got_first <= 1'b0;
                r_have_org  <= 1'b0;
                r_dropped   <= (r_mode == dns_pkg::MODE_APPEND) && w_full;
                if (r_mode == dns_pkg::MODE_CLEAR) begin
                    r_count <= '0;
                end else if (w_wr_en) begin
                    r_count <= r_count + IW'(1);
                end
            end else if (i_cmd.scan_start) begin
                r_idx       <= '0;
                r_scan      <= 1'b1;
                r_have_best <= 1'b0;
            end else if (i_cmd.rd) begin
                r_idx <= r_idx + IW'(1);
            end

            r_v0 <= i_cmd.rd;
            r_va <= r_v0;
            r_vb <= r_va && r_scan;
            r_vc <= r_vb && !r_b_skip && w_cone;
            r_vd <= r_vc;

            // first entry, and first entry carrying the origin identifier
            if (r_va && !r_scan) begin
                r_got_first <= 1'b1;
                if (!r_have_org && (r_a_id == r_vid)) begin
                    r_have_org <= 1'b1;
                end
            end

            if (r_vd && w_better) begin
                r_have_best <= 1'b1;
            end

            if (i_cmd.finish) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_mode <= i_mode;
            r_vid  <= i_view_id;
            r_x    <= i_box_x;
            r_y    <= i_box_y;
            r_w    <= i_box_width;
            r_h    <= i_box_height;
            r_dir  <= i_direction;
        end

        if (r_va && !r_scan) begin
            if (!r_got_first) begin
                r_first_id <= r_a_id;
            end
            if (!r_have_org && (r_a_id == r_vid)) begin
                r_ox <= r_a_cx;
                r_oy <= r_a_cy;
            end
        end

        r_a_id   <= w_q_id;
        r_a_cx   <= w_cx;
        r_a_cy   <= w_cy;

        r_b_id   <= r_a_id;
        r_b_dx   <= DW'(r_a_cx) - DW'(r_ox);
        r_b_dy   <= DW'(r_a_cy) - DW'(r_oy);
        r_b_skip <= (r_a_id == r_vid);

        r_c_id   <= r_b_id;
        r_c_mx   <= w_mx;
        r_c_my   <= w_my;

        r_d_id   <= r_c_id;
        r_d_sqx  <= r_c_mx * r_c_mx;
        r_d_sqy  <= r_c_my * r_c_my;

        if (r_vd && w_better) begin
            r_best_sum <= w_sum;
            r_best_id  <= r_d_id;
        end

        if (i_cmd.finish) begin
            r_out_status <= n_out_status;
            r_out_id     <= n_out_id;
        end
    end

    always_comb begin
        if (r_vid == '0) begin
            w_found    = r_got_first && (r_first_id != '0);
            w_found_id = r_first_id;
        end else begin
            w_found    = r_have_org && r_have_best && (r_best_id != '0);
            w_found_id = r_best_id;
        end
    end

    always_comb begin
        n_out_status = dns_pkg::ST_DONE;
        n_out_id     = '0;
        unique case (r_mode)
            dns_pkg::MODE_QUERY: begin
                if (w_found) begin
                    n_out_status = dns_pkg::ST_FOUND;
                    n_out_id     = w_found_id;
                end else begin
                    n_out_status = dns_pkg::ST_NOT_FOUND;
                end
            end
            dns_pkg::MODE_APPEND: begin
                n_out_status = r_dropped ? dns_pkg::ST_DROPPED : dns_pkg::ST_DONE;
            end
            default: begin
                n_out_status = dns_pkg::ST_DONE;
            end
        endcase
    end

    assign o_sts.is_query  = (r_mode == dns_pkg::MODE_QUERY);
    assign o_sts.vid_zero  = (r_vid == '0);
    assign o_sts.have_org  = r_have_org;
    assign o_sts.idx_done  = (r_idx == r_count);
    assign o_sts.pipe_busy = r_v0 || r_va || r_vb || r_vc || r_vd;
    assign o_sts.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid = r_out_valid;
    assign o_status    = r_out_status;
    assign o_chosen_id = r_out_id;
endmodule

// ----- design/directional_nearest_selector.sv -----
// ----------------------------------------------------------------------------
// directional_nearest_selector
// Table of candidate rectangles with clear, append and directional
// nearest-neighbor query.
//
//   channel   dir   handshake          payload
//   i_req     in    valid / ready      mode, view_id, box_x, box_y,
//                                      box_width, box_height, direction
//   o_rsp     out   valid / ready      status, chosen_id
//
// Clear, append and unused modes go straight from execution to the result.
// Query: the table sits in one RAM with a single read port and is read once
// for the origin search and, for a nonzero view id with its origin found,
// once for the cone scan, one entry per cycle, each pass followed by a drain.
// Reset empties the table (entry count to zero); no clearing pass is run.
// A finished result waits in the output register while the next request is
// taken and run; that request then holds until the register frees.
// ----------------------------------------------------------------------------
module directional_nearest_selector #(
    parameter int MAX_ENTRIES = 64,
    parameter int COORD_BITS  = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    dns_req_if.sink       i_req,
    dns_rsp_if.source     o_rsp
);
    dns_pkg::t_dp_cmd w_cmd;
    dns_pkg::t_dp_sts w_sts;

    dns_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .o_req_ready (i_req.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    dns_datapath #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .COORD_BITS  (COORD_BITS)
    ) u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_mode       (i_req.mode),
        .i_view_id    (i_req.view_id),
        .i_box_x      (i_req.box_x),
        .i_box_y      (i_req.box_y),
        .i_box_width  (i_req.box_width),
        .i_box_height (i_req.box_height),
        .i_direction  (i_req.direction),
        .i_out_ready  (o_rsp.ready),
        .o_out_valid  (o_rsp.valid),
        .o_status     (o_rsp.status),
        .o_chosen_id  (o_rsp.chosen_id)
    );
endmodule

// ----- bench/directional_nearest_selector_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// directional_nearest_selector_test
// Self-checking bench: a queue-fed driver issues clear, append, query and
// unused-mode requests with random gaps, a monitor predicts each result
// from its own copy of the rectangle table and checks every result in order.
// ----------------------------------------------------------------------------
module directional_nearest_selector_test;

    localparam int TABLE_DEPTH    = 64;
    localparam int COORD_W        = 16;
    localparam int ID_W           = dns_pkg::ID_BITS;
    localparam int DIM_W          = dns_pkg::DIM_BITS;
    localparam int RANDOM_ITEMS   = 1250;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int LONG_HOLD      = 400;
    localparam int HOLD_AFTER     = 300;
    localparam int SETTLE_CYCLES  = 200;

    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct {
        logic [1:0]                mode;
        logic [ID_W-1:0]           view_id;
        logic signed [COORD_W-1:0] box_x;
        logic signed [COORD_W-1:0] box_y;
        logic [DIM_W-1:0]          box_width;
        logic [DIM_W-1:0]          box_height;
        logic [1:0]                direction;
        bit                        drain_first;
    } t_request;

    typedef struct {
        logic [1:0]      status;
        logic [ID_W-1:0] chosen_id;
    } t_answer;

    logic i_clk;
    logic i_rst_n;

    dns_req_if #(.COORD_BITS(COORD_W)) req_ch ();
    dns_rsp_if rsp_ch ();

    directional_nearest_selector #(
        .MAX_ENTRIES (TABLE_DEPTH),
        .COORD_BITS  (COORD_W)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // table copy: identifiers and doubled centres
    int              tbl_count;
    logic [ID_W-1:0] tbl_id [TABLE_DEPTH];
    longint          tbl_cx [TABLE_DEPTH];
    longint          tbl_cy [TABLE_DEPTH];

    t_request pending_reqs[$];
    t_answer  expected_answers[$];

    bit req_fired;
    bit rsp_fired;
    int mismatches;
    int rsp_count;
    int idle_cycles;
    int req_gap;
    int req_calm;
    int rsp_stall;
    int rsp_calm;
    int rsp_hold_left;
    bit hold_done;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    function automatic bit in_cone(longint dx, longint dy, logic [1:0] dir);
        longint ax;
        longint ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        case (dir)
            dns_pkg::DIR_LEFT:  return dx < 0 && ay <= ax;
            dns_pkg::DIR_RIGHT: return dx > 0 && ay <= ax;
            dns_pkg::DIR_UP:    return dy < 0 && ax <= ay;
            default:            return dy > 0 && ax <= ay;
        endcase
    endfunction

    // update the table copy and return the result the request must produce
    function automatic t_answer apply_request(t_request r);
        t_answer         a;
        int              org;
        bit              have_best;
        longint          best_d;
        longint          d;
        longint          dx;
        longint          dy;
        logic [ID_W-1:0] best_id;
        a.status    = dns_pkg::ST_DONE;
        a.chosen_id = '0;
        case (r.mode)
            dns_pkg::MODE_CLEAR: tbl_count = 0;
            dns_pkg::MODE_APPEND: begin
                if (tbl_count < TABLE_DEPTH) begin
                    tbl_id[tbl_count] = r.view_id;
                    tbl_cx[tbl_count] = 2 * longint'(r.box_x) + longint'(r.box_width);
                    tbl_cy[tbl_count] = 2 * longint'(r.box_y) + longint'(r.box_height);
                    tbl_count++;
                end else begin
                    a.status = dns_pkg::ST_DROPPED;
                end
            end
            dns_pkg::MODE_QUERY: begin
                a.status = dns_pkg::ST_NOT_FOUND;
                if (tbl_count == 0) begin
                    a.status = dns_pkg::ST_NOT_FOUND;
                end else if (r.view_id == '0) begin
                    if (tbl_id[0] != '0) begin
                        a.status    = dns_pkg::ST_FOUND;
                        a.chosen_id = tbl_id[0];
                    end
                end else begin
                    org = -1;
                    for (int i = 0; i < tbl_count; i++)
                        if (org < 0 && tbl_id[i] == r.view_id)
                            org = i;
                    if (org >= 0) begin
                        have_best = 1'b0;
                        best_d    = 0;
                        best_id   = '0;
                        // skip every entry carrying the origin id
                        for (int i = 0; i < tbl_count; i++) begin
                            if (tbl_id[i] != r.view_id) begin
                                dx = tbl_cx[i] - tbl_cx[org];
                                dy = tbl_cy[i] - tbl_cy[org];
                                if (in_cone(dx, dy, r.direction)) begin
                                    d = dx * dx + dy * dy;
                                    if (!have_best || d < best_d) begin
                                        have_best = 1'b1;
                                        best_d    = d;
                                        best_id   = tbl_id[i];
                                    end
                                end
                            end
                        end
                        if (have_best && best_id != '0) begin
                            a.status    = dns_pkg::ST_FOUND;
                            a.chosen_id = best_id;
                        end
                    end
                end
            end
            default: ;
        endcase
        return a;
    endfunction

    function automatic int draw_gap(inout int calm);
        int roll;
        if (calm > 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            calm = $urandom_range(40, 150);
            return 0;
        end
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic push_request(logic [1:0] mode, logic [ID_W-1:0] vid,
                                logic signed [COORD_W-1:0] x,
                                logic signed [COORD_W-1:0] y,
                                logic [DIM_W-1:0] w, logic [DIM_W-1:0] h,
                                logic [1:0] dir, bit drain);
        t_request r;
        r.mode        = mode;
        r.view_id     = vid;
        r.box_x       = x;
        r.box_y       = y;
        r.box_width   = w;
        r.box_height  = h;
        r.direction   = dir;
        r.drain_first = drain;
        pending_reqs.push_back(r);
    endtask

    task automatic build_directed();
        push_request(dns_pkg::MODE_QUERY, 16'd5, '0, '0, '0, '0, dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd0, '0, '0, '0, '0, dns_pkg::DIR_RIGHT, 1'b0);
        push_request(MODE_UNUSED, 16'hFFFF, 16'sh7FFF, 16'sh8000, 15'h7FFF, 15'h0,
                     dns_pkg::DIR_DOWN, 1'b0);
        // id zero as first entry, most negative corner, largest size
        push_request(dns_pkg::MODE_APPEND, 16'd0, 16'sh8000, 16'sh8000, 15'h7FFF,
                     15'h7FFF, dns_pkg::DIR_UP, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd0, '0, '0, '0, '0, dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_CLEAR, '0, '0, '0, '0, '0, dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_APPEND, 16'hFFFF, 16'sh7FFF, 16'sh7FFF, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_APPEND, 16'd1, 16'sd0, 16'sd0, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_APPEND, 16'd2, -16'sd10, 16'sd0, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_APPEND, 16'd3, 16'sd10, 16'sd0, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_APPEND, 16'd4, 16'sd0, -16'sd10, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_APPEND, 16'd5, 16'sd0, 16'sd10, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        // equal distance to id 2: the earlier entry must win
        push_request(dns_pkg::MODE_APPEND, 16'd6, -16'sd10, 16'sd0, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        // second entry with the origin id, on the cone diagonal: skipped
        push_request(dns_pkg::MODE_APPEND, 16'd1, 16'sd100, 16'sd100, '0, '0,
                     dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd1, '0, '0, '0, '0, dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd1, '0, '0, '0, '0, dns_pkg::DIR_RIGHT, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd1, '0, '0, '0, '0, dns_pkg::DIR_UP, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd1, '0, '0, '0, '0, dns_pkg::DIR_DOWN, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd0, '0, '0, '0, '0, dns_pkg::DIR_DOWN, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd77, '0, '0, '0, '0, dns_pkg::DIR_UP, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd3, '0, '0, '0, '0, dns_pkg::DIR_RIGHT, 1'b0);
        // nearest on the left now has id zero
        push_request(dns_pkg::MODE_APPEND, 16'd0, -16'sd3, 16'sd0, 15'd1, 15'd0,
                     dns_pkg::DIR_LEFT, 1'b0);
        push_request(dns_pkg::MODE_QUERY, 16'd1, '0, '0, '0, '0, dns_pkg::DIR_LEFT, 1'b0);
    endtask

    task automatic build_random(int target);
        logic [ID_W-1:0]           ids[$];
        logic [ID_W-1:0]           vid;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [DIM_W-1:0]          w;
        logic [DIM_W-1:0]          h;
        bit                        tight;
        bit                        drain;
        int                        n_app;
        int                        n_query;
        int                        roll;
        int                        seq;
        seq = 0;
        while (pending_reqs.size() < target) begin
            tight = $urandom_range(0, 3) != 0;
            drain = (seq == 3) || ($urandom_range(0, 19) == 0);
            if ($urandom_range(0, 9) != 0) begin
                push_request(dns_pkg::MODE_CLEAR, ID_W'($urandom()), COORD_W'($urandom()),
                             COORD_W'($urandom()), DIM_W'($urandom()),
                             DIM_W'($urandom()), 2'($urandom()), drain);
                drain = 1'b0;
                ids.delete();
            end
            // now and then overfill the table
            n_app = ($urandom_range(0, 9) == 0) ? $urandom_range(55, 70)
                                                : $urandom_range(1, 14);
            n_query = $urandom_range(1, 8);
            for (int i = 0; i < n_app + n_query; i++) begin
                if (tight) begin
                    vid = ID_W'($urandom_range(0, 15));
                    x   = COORD_W'(int'($urandom_range(0, 128)) - 64);
                    y   = COORD_W'(int'($urandom_range(0, 128)) - 64);
                    w   = DIM_W'($urandom_range(0, 16));
                    h   = DIM_W'($urandom_range(0, 16));
                end else begin
                    vid = ID_W'($urandom());
                    x   = COORD_W'($urandom());
                    y   = COORD_W'($urandom());
                    w   = DIM_W'($urandom());
                    h   = DIM_W'($urandom());
                end
                if (i < n_app) begin
                    ids.push_back(vid);
                    push_request(dns_pkg::MODE_APPEND, vid, x, y, w, h, 2'($urandom()),
                                 drain);
                end else begin
                    roll = $urandom_range(0, 9);
                    if (roll < 6)
                        vid = ids[$urandom_range(0, ids.size() - 1)];
                    else if (roll == 6)
                        vid = '0;
                    if (roll == 8)
                        push_request(MODE_UNUSED, vid, x, y, w, h, 2'($urandom()), drain);
                    else if (roll == 9)
                        push_request(dns_pkg::MODE_APPEND, vid, x, y, w, h,
                                     2'($urandom()), drain);
                    else
                        push_request(dns_pkg::MODE_QUERY, vid, x, y, w, h,
                                     2'($urandom()), drain);
                end
                drain = 1'b0;
            end
            seq++;
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        t_request nxt;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else if (!req_ch.valid || req_fired) begin
            if (req_gap > 0 && rsp_hold_left == 0) begin
                req_gap--;
                req_ch.valid <= 1'b0;
            end else if (pending_reqs.size() == 0 ||
                         (pending_reqs[0].drain_first && expected_answers.size() != 0)) begin
                req_ch.valid <= 1'b0;
            end else begin
                nxt = pending_reqs.pop_front();
                req_ch.valid      <= 1'b1;
                req_ch.mode       <= nxt.mode;
                req_ch.view_id    <= nxt.view_id;
                req_ch.box_x      <= nxt.box_x;
                req_ch.box_y      <= nxt.box_y;
                req_ch.box_width  <= nxt.box_width;
                req_ch.box_height <= nxt.box_height;
                req_ch.direction  <= nxt.direction;
                req_gap = draw_gap(req_calm);
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else if (rsp_hold_left > 0) begin
            rsp_hold_left--;
            rsp_ch.ready <= 1'b0;
        end else if (!hold_done && rsp_count >= HOLD_AFTER) begin
            // hold off long enough for the block to back up its input
            hold_done     = 1'b1;
            rsp_hold_left = LONG_HOLD;
            rsp_ch.ready <= 1'b0;
        end else if (rsp_stall > 0) begin
            rsp_stall--;
            rsp_ch.ready <= 1'b0;
        end else if (rsp_ch.ready && rsp_fired) begin
            rsp_stall = draw_gap(rsp_calm);
            rsp_ch.ready <= (rsp_stall == 0);
            if (rsp_stall > 0)
                rsp_stall--;
        end else begin
            rsp_ch.ready <= 1'b1;
        end
    end

    // monitor, predictor and watchdog
    always @(posedge i_clk) begin
        t_request seen;
        t_answer  want;
        req_fired = i_rst_n && req_ch.valid && req_ch.ready;
        rsp_fired = i_rst_n && rsp_ch.valid && rsp_ch.ready;
        if (rsp_fired) begin
            rsp_count++;
            if (expected_answers.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result: status %0d, chosen_id %0d",
                         $time, rsp_ch.status, rsp_ch.chosen_id);
            end else begin
                want = expected_answers.pop_front();
                if (rsp_ch.status !== want.status) begin
                    mismatches++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                end
                if (rsp_ch.chosen_id !== want.chosen_id) begin
                    mismatches++;
                    $display("%0t: chosen_id mismatch: expected %0d, actual %0d",
                             $time, want.chosen_id, rsp_ch.chosen_id);
                end
            end
        end
        if (req_fired) begin
            seen.mode        = req_ch.mode;
            seen.view_id     = req_ch.view_id;
            seen.box_x       = req_ch.box_x;
            seen.box_y       = req_ch.box_y;
            seen.box_width   = req_ch.box_width;
            seen.box_height  = req_ch.box_height;
            seen.direction   = req_ch.direction;
            seen.drain_first = 1'b0;
            expected_answers.push_back(apply_request(seen));
        end
        if (req_fired || rsp_fired)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("directional_nearest_selector test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.mode       = dns_pkg::MODE_CLEAR;
        req_ch.view_id    = '0;
        req_ch.box_x      = '0;
        req_ch.box_y      = '0;
        req_ch.box_width  = '0;
        req_ch.box_height = '0;
        req_ch.direction  = dns_pkg::DIR_LEFT;
        rsp_ch.ready      = 1'b0;
        tbl_count         = 0;
        mismatches        = 0;
        rsp_count         = 0;
        idle_cycles       = 0;
        req_gap           = 0;
        req_calm          = 0;
        rsp_stall         = 0;
        rsp_calm          = 0;
        rsp_hold_left     = 0;
        hold_done         = 1'b0;
        req_fired         = 1'b0;
        rsp_fired         = 1'b0;
        build_directed();
        build_random(pending_reqs.size() + RANDOM_ITEMS);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        while (pending_reqs.size() != 0 || req_ch.valid || expected_answers.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("directional_nearest_selector test passed");
        else
            $display("directional_nearest_selector test failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
design/dns_pkg.sv
design/dns_req_if.sv
design/dns_rsp_if.sv
design/dns_ram.sv
design/dns_ctrl.sv
design/dns_datapath.sv
design/directional_nearest_selector.sv
bench/directional_nearest_selector_test.sv
